// File: rtl/core/clt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants of the channel lease table
// Slot count, operation and actor codes, transaction payloads and the
// per-slot record.
// ----------------------------------------------------------------------------
package clt_pkg;

    // number of channel slots (1 to 16)
    localparam int CHANNELS = 4;

    // fixed field widths
    localparam int MODE_W  = 3;
    localparam int CHAN_W  = 4;
    localparam int ACTOR_W = 2;
    localparam int GEN_W   = 32;
    localparam int TIME_W  = 32;

    // slot index width, at least one bit
    localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // channel codes at or above this limit are invalid
    localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);

    // operation codes
    localparam logic [MODE_W-1:0] MODE_BEGIN      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REQ_CANCEL = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FINISH     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MANUAL     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STATUS     = 3'd5;

    // permitted actor codes
    localparam logic [ACTOR_W-1:0] ACTOR_AGENT  = 2'd1;
    localparam logic [ACTOR_W-1:0] ACTOR_CLIENT = 2'd2;

    // request transaction payload
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CHAN_W-1:0]  channel;
        logic [ACTOR_W-1:0] actor;
        logic [GEN_W-1:0]   token_generation;
        logic [TIME_W-1:0]  start_time;
    } req_t;

    // response transaction payload
    typedef struct packed {
        logic               ok;
        logic [GEN_W-1:0]   lease_generation;
        logic               slot_active;
        logic               slot_cancel;
        logic [ACTOR_W-1:0] slot_actor;
        logic [TIME_W-1:0]  slot_start_time;
    } rsp_t;

    // one lease slot
    typedef struct packed {
        logic               active;
        logic               cancel;
        logic [GEN_W-1:0]   generation;
        logic [ACTOR_W-1:0] actor;
        logic [TIME_W-1:0]  start_time;
    } slot_t;

endpackage : clt_pkg
`default_nettype wire

// File: rtl/core/clt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_if: valid/ready channels of the channel lease table
// Request and response channels, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface clt_req_if;
    logic          valid;
    logic          ready;
    clt_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : clt_req_if

interface clt_rsp_if;
    logic          valid;
    logic          ready;
    clt_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : clt_rsp_if
`default_nettype wire

// File: rtl/core/channel_lease_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// channel_lease_table: generation-tagged lease slots
// Grants, cancels, queries and finishes leases on a small table of channel
// slots, one operation per transaction, one response per request.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | transfer
//  --------+-----+-------------------------------------------+---------------
//  req     | in  | mode, channel, actor, token_gen, start    | valid & ready
//  rsp     | out | ok, lease_gen, slot act/cancel/actor/time | valid & ready
//
//  One request per cycle while rsp is ready, through the request register
//  and then the response register. The slot read, compare, generation
//  increment and write all sit between those two registers, so a following
//  request to the same slot sees the update. Reset clears every slot at
//  once. A stalled response holds the pipe; the request register still
//  takes a transaction while a response waits if the request stage is empty.
// ----------------------------------------------------------------------------
module channel_lease_table (
    input  wire        clk,
    input  wire        rst_n,
    clt_req_if.sink    req,
    clt_rsp_if.source  rsp
);
    import clt_pkg::*;

    // request stage
    logic  in_valid_reg;
    req_t  in_data_reg;

    // response stage
    logic  out_valid_reg;
    rsp_t  out_data_reg;

    // slot table
    slot_t slot_reg [CHANNELS];

    logic              advance;
    logic [SLOT_W-1:0] idx;
    logic              chan_ok;
    slot_t             slot_cur;
    logic              tok_match;
    logic [GEN_W-1:0]  gen_inc;
    rsp_t              out_data_next;
    slot_t             slot_next;
    logic              slot_we;

    // status vectors for checks
    logic [CHANNELS-1:0] active_vec;
    logic [CHANNELS-1:0] cancel_vec;
    logic [CHANNELS-1:0] zero_gen_vec;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
    end

    // slot lookup
    assign idx       = in_data_reg.channel[SLOT_W-1:0];
    assign chan_ok   = ({1'b0, in_data_reg.channel} < CHAN_LIMIT);
    assign slot_cur  = slot_reg[idx];
    assign tok_match = (in_data_reg.token_generation != '0) && slot_cur.active
                       && (slot_cur.generation == in_data_reg.token_generation);
    assign gen_inc   = (slot_cur.generation == '1) ? GEN_W'(1)
                                                   : slot_cur.generation + GEN_W'(1);

    // operation decode
    always_comb
    begin
        out_data_next = '0;
        slot_next     = slot_cur;
        slot_we       = 1'b0;
        case (in_data_reg.mode)
            MODE_BEGIN:
            begin
                if (chan_ok && !slot_cur.active
                    && (in_data_reg.actor inside {ACTOR_AGENT, ACTOR_CLIENT}))
                begin
                    slot_next.active     = 1'b1;
                    slot_next.cancel     = 1'b0;
                    slot_next.generation = gen_inc;
                    slot_next.actor      = in_data_reg.actor;
                    slot_next.start_time = in_data_reg.start_time;
                    slot_we              = 1'b1;
                    out_data_next.ok               = 1'b1;
                    out_data_next.lease_generation = gen_inc;
                end
            end
            MODE_REQ_CANCEL:
            begin
                if (chan_ok && tok_match)
                begin
                    slot_next.cancel = 1'b1;
                    slot_we          = 1'b1;
                    out_data_next.ok = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                out_data_next.ok = !chan_ok || (in_data_reg.token_generation == '0)
                                   || !slot_cur.active
                                   || (slot_cur.generation != in_data_reg.token_generation)
                                   || slot_cur.cancel;
            end
            MODE_FINISH:
            begin
                if (chan_ok && tok_match)
                begin
                    slot_next.active     = 1'b0;
                    slot_next.cancel     = 1'b0;
                    slot_next.actor      = '0;
                    slot_next.start_time = '0;
                    slot_we              = 1'b1;
                    out_data_next.ok     = 1'b1;
                end
            end
            MODE_MANUAL:
            begin
                out_data_next.ok = chan_ok && !slot_cur.active;
            end
            MODE_STATUS:
            begin
                if (chan_ok)
                begin
                    out_data_next.ok               = 1'b1;
                    out_data_next.lease_generation = slot_cur.generation;
                    out_data_next.slot_active      = slot_cur.active;
                    out_data_next.slot_cancel      = slot_cur.cancel;
                    out_data_next.slot_actor       = slot_cur.actor;
                    out_data_next.slot_start_time  = slot_cur.start_time;
                end
            end
            default:
            begin
                out_data_next = '0;
            end
        endcase
    end

    // slot table update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (advance && slot_we)
        begin
            slot_reg[idx] <= slot_next;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // flatten slot flags for checks
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            active_vec[i]   = slot_reg[i].active;
            cancel_vec[i]   = slot_reg[i].cancel;
            zero_gen_vec[i] = (slot_reg[i].generation == '0);
        end
    end

    // a cancel mark only exists on a live lease
    a_cancel_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cancel_vec & ~active_vec) == '0)
        else $error("cancel flag set on idle slot");

    // a live lease never carries generation zero
    a_active_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (active_vec & zero_gen_vec) == '0)
        else $error("active slot with zero generation");

    // a granted begin hands out a nonzero token
    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_data_reg.mode == MODE_BEGIN) && out_data_next.ok)
        |-> (out_data_next.lease_generation != '0))
        else $error("begin granted generation zero");

    // a failed operation reports no slot data
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.ok)
        |-> (out_data_reg.lease_generation == '0 && !out_data_reg.slot_active
             && !out_data_reg.slot_cancel && out_data_reg.slot_actor == '0
             && out_data_reg.slot_start_time == '0))
        else $error("failed transaction carries slot data");

    // a transaction taken in the request stage moves on or is held
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("request stage lost a transaction");

endmodule : channel_lease_table
`default_nettype wire

// File: dv/channel_lease_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_lease_table_checker: response scoreboard for the lease table
// Watches both channels, keeps its own copy of the slot table, works out
// the response of every accepted request and compares each accepted
// response field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module channel_lease_table_checker (
    input  wire                                           clk,
    input  wire                                           rst_n,
    input  wire                                           req_valid,
    input  wire                                           req_ready,
    input  clt_pkg::req_t                                 req_data,
    input  wire                                           rsp_valid,
    input  wire                                           rsp_ready,
    input  clt_pkg::rsp_t                                 rsp_data,
    output int                                            mismatches,
    output int                                            outstanding,
    output int                                            responses_checked,
    output int                                            leases_granted,
    output logic [clt_pkg::CHANNELS-1:0][clt_pkg::GEN_W-1:0] lease_gen_hint
);
    import clt_pkg::*;

    // shadow slot table and responses still owed, oldest first
    slot_t lease_slots [CHANNELS];
    rsp_t  owed_responses [$];

    // apply one operation to the shadow table and return its response
    function automatic rsp_t predict_lease_op(input req_t r);
        rsp_t              res;
        slot_t             s;
        logic              chan_ok;
        logic              token_hit;
        logic [SLOT_W-1:0] idx;
        logic [GEN_W-1:0]  next_gen;
        res       = '0;
        chan_ok   = ({1'b0, r.channel} < CHAN_LIMIT);
        idx       = chan_ok ? r.channel[SLOT_W-1:0] : '0;
        s         = lease_slots[idx];
        token_hit = chan_ok && (r.token_generation != '0) && s.active &&
                    (s.generation == r.token_generation);
        case (r.mode)
            MODE_BEGIN:
            begin
                if (chan_ok && !s.active &&
                    (r.actor == ACTOR_AGENT || r.actor == ACTOR_CLIENT))
                begin
                    // generation skips zero on wrap
                    next_gen = s.generation + GEN_W'(1);
                    if (next_gen == '0)
                        next_gen = GEN_W'(1);
                    s.active             = 1'b1;
                    s.cancel             = 1'b0;
                    s.generation         = next_gen;
                    s.actor              = r.actor;
                    s.start_time         = r.start_time;
                    res.ok               = 1'b1;
                    res.lease_generation = next_gen;
                end
            end
            MODE_REQ_CANCEL:
            begin
                if (token_hit)
                begin
                    s.cancel = 1'b1;
                    res.ok   = 1'b1;
                end
            end
            MODE_QUERY:
            begin
                // stale or bad tokens tell the holder to stop
                res.ok = !chan_ok || (r.token_generation == '0) || !s.active ||
                         (s.generation != r.token_generation) || s.cancel;
            end
            MODE_FINISH:
            begin
                // generation survives so old tokens go stale
                if (token_hit)
                begin
                    s.active     = 1'b0;
                    s.cancel     = 1'b0;
                    s.actor      = '0;
                    s.start_time = '0;
                    res.ok       = 1'b1;
                end
            end
            MODE_MANUAL:
            begin
                res.ok = chan_ok && !s.active;
            end
            MODE_STATUS:
            begin
                if (chan_ok)
                begin
                    res.ok               = 1'b1;
                    res.lease_generation = s.generation;
                    res.slot_active      = s.active;
                    res.slot_cancel      = s.cancel;
                    res.slot_actor       = s.actor;
                    res.slot_start_time  = s.start_time;
                end
            end
            default:
            begin
            end
        endcase
        if (chan_ok)
            lease_slots[idx] = s;
        return res;
    endfunction

    // predict on every request transaction, compare on every response one
    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t pred;
        rsp_t want;
        logic bad;
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                lease_slots[i] = '0;
            owed_responses.delete();
            mismatches        = 0;
            outstanding       = 0;
            responses_checked = 0;
            leases_granted    = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                pred = predict_lease_op(req_data);
                if (req_data.mode == MODE_BEGIN && pred.ok)
                    leases_granted++;
                owed_responses.push_back(pred);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (owed_responses.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: response with nothing owed: ok=%0b gen=%08h",
                                 $realtime, rsp_data.ok, rsp_data.lease_generation);
                    mismatches++;
                end
                else
                begin
                    want = owed_responses.pop_front();
                    responses_checked++;
                    bad = (rsp_data.ok !== want.ok) ||
                          (rsp_data.lease_generation !== want.lease_generation) ||
                          (rsp_data.slot_active !== want.slot_active) ||
                          (rsp_data.slot_cancel !== want.slot_cancel) ||
                          (rsp_data.slot_actor !== want.slot_actor) ||
                          (rsp_data.slot_start_time !== want.slot_start_time);
                    if (bad)
                    begin
                        if (mismatches < 10)
                        begin
                            $display({"%0t: mismatch exp ok=%0b gen=%08h act=%0b",
                                      " can=%0b actor=%0d start=%08h"},
                                     $realtime, want.ok, want.lease_generation,
                                     want.slot_active, want.slot_cancel,
                                     want.slot_actor, want.slot_start_time);
                            $display({"%0t:          got ok=%0b gen=%08h act=%0b",
                                      " can=%0b actor=%0d start=%08h"},
                                     $realtime, rsp_data.ok, rsp_data.lease_generation,
                                     rsp_data.slot_active, rsp_data.slot_cancel,
                                     rsp_data.slot_actor, rsp_data.slot_start_time);
                        end
                        mismatches++;
                    end
                end
            end
            outstanding = owed_responses.size();
        end
    end

    // generations for the stimulus side, stable across the rising edge
    always @(negedge clk)
    begin
        for (int i = 0; i < CHANNELS; i++)
            lease_gen_hint[i] <= lease_slots[i].generation;
    end

endmodule : channel_lease_table_checker

// File: dv/channel_lease_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// channel_lease_table_test: top level of the lease table testbench
// Drives a directed pass over every operation and corner, then three
// random phases of lease sessions under varying idle on both channels;
// the checker beside the block scores every response.
// ----------------------------------------------------------------------------
module channel_lease_table_test;
    import clt_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int DRAIN_CYCLES     = 8;

    // codes the block treats as unused or rejected
    localparam logic [MODE_W-1:0]  MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0]  MODE_SPARE_HI = 3'd7;
    localparam logic [ACTOR_W-1:0] ACTOR_NONE    = 2'd0;
    localparam logic [ACTOR_W-1:0] ACTOR_BAD     = 2'd3;
    localparam logic [CHAN_W-1:0]  CHAN_TOP      = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    int   cycle_count   = 0;
    int   sent_by_mode [8];

    int   mismatches;
    int   outstanding;
    int   responses_checked;
    int   leases_granted;
    logic [CHANNELS-1:0][GEN_W-1:0] lease_gen_hint;

    clt_req_if req_ch ();
    clt_rsp_if rsp_ch ();

    channel_lease_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    channel_lease_table_checker lease_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_valid         (req_ch.valid),
        .req_ready         (req_ch.ready),
        .req_data          (req_ch.data),
        .rsp_valid         (rsp_ch.valid),
        .rsp_ready         (rsp_ch.ready),
        .rsp_data          (rsp_ch.data),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .responses_checked (responses_checked),
        .leases_granted    (leases_granted),
        .lease_gen_hint    (lease_gen_hint)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** channel_lease_table: FAILED **");
            $finish;
        end
    end

    // response side back-pressure
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);

    function automatic req_t lease_request(input logic [MODE_W-1:0] mode,
                                           input logic [CHAN_W-1:0] channel,
                                           input logic [ACTOR_W-1:0] actor,
                                           input logic [GEN_W-1:0] token,
                                           input logic [TIME_W-1:0] start);
        req_t r;
        r.mode             = mode;
        r.channel          = channel;
        r.actor            = actor;
        r.token_generation = token;
        r.start_time       = start;
        return r;
    endfunction

    // mostly well-formed lease traffic with live tokens, plus noise
    function automatic req_t random_lease_request();
        req_t             r;
        int               pick;
        logic [GEN_W-1:0] live_gen;
        pick = $urandom_range(99);
        if (pick < 22)
            r.mode = MODE_BEGIN;
        else if (pick < 38)
            r.mode = MODE_REQ_CANCEL;
        else if (pick < 54)
            r.mode = MODE_QUERY;
        else if (pick < 74)
            r.mode = MODE_FINISH;
        else if (pick < 82)
            r.mode = MODE_MANUAL;
        else if (pick < 95)
            r.mode = MODE_STATUS;
        else
            r.mode = MODE_W'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));

        if (CHANNELS >= (1 << CHAN_W) || $urandom_range(99) < 85)
            r.channel = CHAN_W'($urandom_range(CHANNELS - 1, 0));
        else
            r.channel = CHAN_W'($urandom_range(CHAN_TOP, CHANNELS));

        if ($urandom_range(99) < 85)
            r.actor = $urandom_range(1) ? ACTOR_AGENT : ACTOR_CLIENT;
        else
            r.actor = $urandom_range(1) ? ACTOR_NONE : ACTOR_BAD;

        live_gen = ({1'b0, r.channel} < CHAN_LIMIT) ?
                   lease_gen_hint[r.channel[SLOT_W-1:0]] : $urandom;
        pick = $urandom_range(99);
        if (pick < 65)
            r.token_generation = live_gen;
        else if (pick < 75)
            r.token_generation = $urandom_range(1) ? live_gen + GEN_W'(1)
                                                   : live_gen - GEN_W'(1);
        else if (pick < 85)
            r.token_generation = '0;
        else
            r.token_generation = $urandom;

        pick = $urandom_range(99);
        if (pick < 5)
            r.start_time = '0;
        else if (pick < 10)
            r.start_time = '1;
        else
            r.start_time = $urandom;
        return r;
    endfunction

    // go quiet for a share of the cycles, then present one request
    // and hold it until taken
    task automatic issue_request(input req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_by_mode[r.mode]++;
    endtask

    // stop sending until every owed response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int n;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < 8; i++)
            sent_by_mode[i] = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fresh slot, full lease life, stale tokens, bad inputs
        issue_request(lease_request(MODE_STATUS, 4'd0, ACTOR_NONE, '0, '0));
        issue_request(lease_request(MODE_MANUAL, 4'd0, ACTOR_NONE, '0, '0));
        issue_request(lease_request(MODE_QUERY, 4'd0, ACTOR_AGENT, '0, '0));
        issue_request(lease_request(MODE_BEGIN, 4'd0, ACTOR_AGENT, '0, '1));
        issue_request(lease_request(MODE_BEGIN, 4'd0, ACTOR_CLIENT, '0, 32'h1234_5678));
        issue_request(lease_request(MODE_MANUAL, 4'd0, ACTOR_AGENT, '0, '0));
        issue_request(lease_request(MODE_QUERY, 4'd0, ACTOR_AGENT, 32'd1, '0));
        issue_request(lease_request(MODE_REQ_CANCEL, 4'd0, ACTOR_AGENT, 32'd2, '0));
        issue_request(lease_request(MODE_REQ_CANCEL, 4'd0, ACTOR_AGENT, 32'd1, '0));
        issue_request(lease_request(MODE_QUERY, 4'd0, ACTOR_AGENT, 32'd1, '0));
        issue_request(lease_request(MODE_STATUS, 4'd0, ACTOR_NONE, '0, '0));
        issue_request(lease_request(MODE_FINISH, 4'd0, ACTOR_AGENT, '0, '0));
        issue_request(lease_request(MODE_FINISH, 4'd0, ACTOR_AGENT, 32'd1, '0));
        issue_request(lease_request(MODE_FINISH, 4'd0, ACTOR_AGENT, 32'd1, '0));
        issue_request(lease_request(MODE_QUERY, 4'd0, ACTOR_AGENT, 32'd1, '0));
        issue_request(lease_request(MODE_BEGIN, 4'd0, ACTOR_NONE, '0, '1));
        issue_request(lease_request(MODE_BEGIN, 4'd0, ACTOR_BAD, '0, '1));
        issue_request(lease_request(MODE_BEGIN, CHAN_W'(CHANNELS - 1), ACTOR_CLIENT, '1, '0));
        issue_request(lease_request(MODE_BEGIN, CHAN_TOP, ACTOR_AGENT, '0, '1));
        issue_request(lease_request(MODE_QUERY, CHAN_TOP, ACTOR_AGENT, '1, '0));
        issue_request(lease_request(MODE_MANUAL, CHAN_TOP, ACTOR_AGENT, '0, '0));
        issue_request(lease_request(MODE_STATUS, CHAN_TOP, ACTOR_AGENT, '0, '0));
        issue_request(lease_request(MODE_SPARE_LO, 4'd0, ACTOR_AGENT, 32'd1, '1));
        issue_request(lease_request(MODE_SPARE_HI, CHAN_TOP, ACTOR_BAD, '1, '1));
        issue_request(lease_request(MODE_BEGIN, 4'd0, ACTOR_CLIENT, '0, 32'hA5A5_5A5A));
        drain_responses();

        // random phases: receiver-light, sender-light, then full rate
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 28;
                    sink_idle_pct = 76;
                end
                1:
                begin
                    src_idle_pct  = 76;
                    sink_idle_pct = 28;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == RANDOM_PER_PHASE / 2)
                    drain_responses();
                issue_request(random_lease_request());
            end
        end

        // wind down
        req_ch.valid <= 1'b0;
        sink_idle_pct = 0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display({"run: begin %0d, cancel %0d, query %0d, finish %0d,",
                  " manual %0d, status %0d, spare %0d"},
                 sent_by_mode[MODE_BEGIN], sent_by_mode[MODE_REQ_CANCEL],
                 sent_by_mode[MODE_QUERY], sent_by_mode[MODE_FINISH],
                 sent_by_mode[MODE_MANUAL], sent_by_mode[MODE_STATUS],
                 sent_by_mode[MODE_SPARE_LO] + sent_by_mode[MODE_SPARE_HI]);
        $display("run: %0d responses scored, %0d leases granted, %0d mismatches in %0d cycles",
                 responses_checked, leases_granted, mismatches, cycle_count);
        if (mismatches == 0 && outstanding == 0)
            $display("** channel_lease_table: PASSED **");
        else
            $display("** channel_lease_table: FAILED **");
        $finish;
    end

endmodule : channel_lease_table_test
